// ----- rtl/spq_pkg.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue package
// Shared codes, field widths and the per-cycle control word of the cell chain.
// ----------------------------------------------------------------------------
`default_nettype none

package spq_pkg;

    localparam int ACTION_W  = 2;
    localparam int STATUS_W  = 2;
    localparam int CAP_W     = 5;

    localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

    localparam logic [ACTION_W-1:0] ACT_INSERT = 2'd0;
    localparam logic [ACTION_W-1:0] ACT_REMOVE = 2'd1;
    localparam logic [ACTION_W-1:0] ACT_PEEK   = 2'd2;

    localparam logic [STATUS_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STATUS_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = 2'd2;

    typedef struct packed {
        logic insert;
        logic remove;
    } t_cell_ctrl;

endpackage

`default_nettype wire

// ----- rtl/spq_cell.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue cell
// Holds one stored value; on insert it keeps, takes the new value or takes its
// upper neighbor's value, and on remove it takes its lower neighbor's value.
// ----------------------------------------------------------------------------
`default_nettype none

module spq_cell #(
    parameter int VALUE_WIDTH = 32
) (
    input  wire                           i_clk,
    input  spq_pkg::t_cell_ctrl           i_ctrl,
    input  wire signed [VALUE_WIDTH-1:0]  i_item,
    input  wire                           i_occupied,
    input  wire                           i_prev_go,
    input  wire signed [VALUE_WIDTH-1:0]  i_prev_value,
    input  wire signed [VALUE_WIDTH-1:0]  i_next_value,
    output logic                          o_go,
    output logic signed [VALUE_WIDTH-1:0] o_value
);
    import spq_pkg::*;

    logic signed [VALUE_WIDTH-1:0] r_value;
    logic signed [VALUE_WIDTH-1:0] n_value;

    // A new value goes ahead of every stored value it does not exceed, so the
    // newest of equal values sits nearest the head.
    assign o_go    = !i_occupied || (i_item <= r_value);
    assign o_value = r_value;

    always_comb begin
        n_value = r_value;
        if (i_ctrl.insert && o_go) begin
            n_value = i_prev_go ? i_prev_value : i_item;
        end else if (i_ctrl.remove) begin
            n_value = i_next_value;
        end
    end

    always_ff @(posedge i_clk) begin
        r_value <= n_value;
    end

endmodule

`default_nettype wire

// ----- rtl/sorted_priority_queue_unit.sv -----
// ----------------------------------------------------------------------------
// Sorted priority queue unit
// Min-priority queue built as a chain of cells kept in ascending order.
// ----------------------------------------------------------------------------
// A request is taken at a rising edge where start is high and busy is low;
// action selects insert, remove-minimum or peek-minimum. busy stays low, so a
// new request may be issued in every cycle.
// Each request gives one result on the cycle after it is taken, marked by
// o_result_valid for exactly one cycle: the removed or peeked minimum, a
// status, the count after the request and the empty and full flags. The
// receiver cannot stall; a result not taken in that cycle is gone.
// Throughput is one request per cycle: every cell of the chain compares its
// value with the new one and shifts in the same cycle.
// The capacity register is written through the configuration channel, which
// is always ready; values above DEPTH act as DEPTH.
// Reset empties the queue and sets capacity to 16. Stored values are not
// cleared; only slots below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none

module sorted_priority_queue_unit #(
    parameter  int DEPTH       = 16,
    parameter  int VALUE_WIDTH = 32,
    localparam int CNT_W       = $clog2(DEPTH + 1)
) (
    input  wire                                  i_clk,
    input  wire                                  i_rst_n,
    input  wire                                  start,
    output logic                                 busy,
    input  wire  [spq_pkg::ACTION_W-1:0]         i_action,
    input  wire  signed [VALUE_WIDTH-1:0]        i_item_value,
    input  wire                                  i_cfg_valid,
    output logic                                 o_cfg_ready,
    input  wire  [spq_pkg::CAP_W-1:0]            i_cfg_capacity,
    output logic                                 o_result_valid,
    output logic signed [VALUE_WIDTH-1:0]        o_min_value,
    output logic [spq_pkg::STATUS_W-1:0]         o_status,
    output logic [CNT_W-1:0]                     o_count,
    output logic                                 o_is_empty,
    output logic                                 o_is_full
);
    import spq_pkg::*;

    localparam int LW = (CNT_W > CAP_W) ? CNT_W : CAP_W;

    logic [CAP_W-1:0]              r_capacity;
    logic [CNT_W-1:0]              r_occupancy;
    logic [CNT_W-1:0]              n_occupancy;
    logic                          r_result_valid;
    logic signed [VALUE_WIDTH-1:0] r_min_value;
    logic signed [VALUE_WIDTH-1:0] n_min_value;
    logic [STATUS_W-1:0]           r_status;
    logic [STATUS_W-1:0]           n_status;
    logic                          r_is_full;

    logic                          accept;
    logic                          cur_full;
    logic                          next_full;
    t_cell_ctrl                    ctrl;

    logic                          w_go    [DEPTH];
    logic signed [VALUE_WIDTH-1:0] w_value [DEPTH];

    assign busy        = 1'b0;
    assign o_cfg_ready = 1'b1;
    assign accept      = start && !busy;

    assign cur_full  = (r_occupancy >= CNT_W'(DEPTH)) ||
                       (LW'(r_occupancy) >= LW'(r_capacity));
    assign next_full = (n_occupancy >= CNT_W'(DEPTH)) ||
                       (LW'(n_occupancy) >= LW'(r_capacity));

    always_comb begin
        n_occupancy = r_occupancy;
        n_min_value = '0;
        n_status    = STATUS_OK;
        ctrl        = '0;
        if (accept) begin
            unique case (i_action)
                ACT_INSERT: begin
                    if (cur_full) begin
                        n_status = STATUS_FULL;
                    end else begin
                        ctrl.insert = 1'b1;
                        n_occupancy = r_occupancy + CNT_W'(1);
                    end
                end
                ACT_REMOVE, ACT_PEEK: begin
                    if (r_occupancy == '0) begin
                        n_status = STATUS_EMPTY;
                    end else begin
                        n_min_value = w_value[0];
                        if (i_action == ACT_REMOVE) begin
                            ctrl.remove = 1'b1;
                            n_occupancy = r_occupancy - CNT_W'(1);
                        end
                    end
                end
                default: begin
                end
            endcase
        end
    end

    genvar g;
    generate
        for (g = 0; g < DEPTH; g++) begin : g_cell
            logic                          prev_go;
            logic signed [VALUE_WIDTH-1:0] prev_value;
            logic signed [VALUE_WIDTH-1:0] next_value;

            if (g == 0) begin : g_head
                assign prev_go    = 1'b0;
                assign prev_value = i_item_value;
            end else begin : g_body
                assign prev_go    = w_go[g-1];
                assign prev_value = w_value[g-1];
            end

            if (g == DEPTH - 1) begin : g_tail
                assign next_value = w_value[g];
            end else begin : g_link
                assign next_value = w_value[g+1];
            end

            spq_cell #(
                .VALUE_WIDTH (VALUE_WIDTH)
            ) u_cell (
                .i_clk        (i_clk),
                .i_ctrl       (ctrl),
                .i_item       (i_item_value),
                .i_occupied   (r_occupancy > CNT_W'(g)),
                .i_prev_go    (prev_go),
                .i_prev_value (prev_value),
                .i_next_value (next_value),
                .o_go         (w_go[g]),
                .o_value      (w_value[g])
            );
        end
    endgenerate

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_capacity     <= CAP_RESET;
            r_occupancy    <= '0;
            r_result_valid <= 1'b0;
        end else begin
            if (i_cfg_valid && o_cfg_ready) begin
                r_capacity <= i_cfg_capacity;
            end
            r_occupancy    <= n_occupancy;
            r_result_valid <= accept;
        end
    end

    always_ff @(posedge i_clk) begin
        r_min_value <= n_min_value;
        r_status    <= n_status;
        r_is_full   <= next_full;
    end

    assign o_result_valid = r_result_valid;
    assign o_min_value    = r_min_value;
    assign o_status       = r_status;
    assign o_count        = r_occupancy;
    assign o_is_empty     = (r_occupancy == '0);
    assign o_is_full      = r_is_full;

    a_occ_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_occupancy <= CNT_W'(DEPTH))
        else $error("occupancy exceeds depth");

    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        accept |=> o_result_valid)
        else $error("accepted request gave no result");

    a_no_stray_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !accept |=> !o_result_valid)
        else $error("result without a request");

    a_error_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_result_valid && o_status != STATUS_OK) |-> (o_min_value == '0))
        else $error("error result carries a value");

    a_refused_holds: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (accept && i_action == ACT_INSERT && cur_full) |=> $stable(r_occupancy))
        else $error("refused insert changed the count");

endmodule

`default_nettype wire
